/* hdl/etsa_pkg.sv */
`default_nettype none
package etsa_pkg;

  localparam int COUNT_WIDTH     = 16;
  localparam int ALPHA_FRAC_BITS = 16;
  localparam int ALPHA_W         = 16;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd6242;

  localparam int PRICE_W    = 32;
  localparam int AVG_W      = 48;
  localparam int WIDE_SHIFT = AVG_W - PRICE_W;
  localparam int DIFF_W     = AVG_W + 1;
  localparam int LO_W       = 24;
  localparam int HI_W       = DIFF_W - LO_W;
  localparam int PLO_W      = LO_W + ALPHA_W;
  localparam int PHI_W      = HI_W + ALPHA_W;
  localparam int SUM_W      = DIFF_W + ALPHA_W + 1;
  localparam int STEP_W     = SUM_W - ALPHA_FRAC_BITS;
  localparam int NEXT_W     = STEP_W + 1;

  localparam int SHARE_W    = 17;
  localparam int TOTAL_W    = 16;
  localparam int NUM_W      = COUNT_WIDTH + SHARE_W + 1;
  localparam int REM_W      = COUNT_WIDTH + 2;
  localparam int DCNT_W     = $clog2(SHARE_W);
  localparam int OUT_BITS   = SHARE_W + 2 * TOTAL_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_SAMPLE,
    KIND_END,
    KIND_SAMPLE_END
  } kind_t;

  typedef struct packed {
    logic [PRICE_W-1:0] price;
    kind_t              kind;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_STEP,
    ST_UPD,
    ST_DIVSET,
    ST_DIV,
    ST_DONE
  } back_state_t;

  function automatic logic [TOTAL_W-1:0] sat_total(input logic [COUNT_WIDTH-1:0] cnt);
    logic [63:0] ext;
    ext = 64'(cnt);
    if (ext > 64'((64'd1 << TOTAL_W) - 64'd1)) begin
      return '1;
    end
    return ext[TOTAL_W-1:0];
  endfunction

endpackage
`default_nettype wire

/* hdl/etsa_front.sv */
`default_nettype none
module etsa_front (
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [etsa_pkg::PRICE_W-1:0]  in_tdata,   // [31:0] price
  input  wire logic                          in_tuser,   // [0] missing
  input  wire logic                          in_tlast,
  input  wire etsa_pkg::q_status_t           q_status,
  output logic                               push,
  output etsa_pkg::q_entry_t                 push_entry
);

  logic accept;

  // A missing sample that does not close a series changes nothing and is dropped here.
  assign in_tready = !q_status.full;
  assign accept    = in_tvalid && in_tready;
  assign push      = accept && !(in_tuser && !in_tlast);

  always_comb begin
    push_entry.price = in_tdata;
    if (in_tuser) begin
      push_entry.kind = etsa_pkg::KIND_END;
    end else if (in_tlast) begin
      push_entry.kind = etsa_pkg::KIND_SAMPLE_END;
    end else begin
      push_entry.kind = etsa_pkg::KIND_SAMPLE;
    end
  end

endmodule
`default_nettype wire

/* hdl/etsa_fifo.sv */
`default_nettype none
module etsa_fifo (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire etsa_pkg::q_entry_t  push_entry,
  input  wire logic                pop,
  output etsa_pkg::q_entry_t       head,
  output etsa_pkg::q_status_t      status
);

  etsa_pkg::q_entry_t               mem_r [etsa_pkg::QUEUE_DEPTH];
  logic [etsa_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [etsa_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [etsa_pkg::QCNT_W-1:0]      cnt_r, cnt_nxt;
  logic                             do_push, do_pop;

  assign status.full  = (cnt_r == etsa_pkg::QCNT_W'(etsa_pkg::QUEUE_DEPTH));
  assign status.empty = (cnt_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == etsa_pkg::QPTR_W'(etsa_pkg::QUEUE_DEPTH - 1)) ? '0
                   : wr_ptr_r + etsa_pkg::QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == etsa_pkg::QPTR_W'(etsa_pkg::QUEUE_DEPTH - 1)) ? '0
                   : rd_ptr_r + etsa_pkg::QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + etsa_pkg::QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - etsa_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule
`default_nettype wire

/* hdl/etsa_back.sv */
`default_nettype none
module etsa_back (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [etsa_pkg::ALPHA_W-1:0]      cfg_wdata,
  input  wire etsa_pkg::q_entry_t                head,
  input  wire etsa_pkg::q_status_t               q_status,
  output logic                                   pop,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [etsa_pkg::OUT_DATA_W-1:0]        out_tdata,
  output logic                                   out_tuser
);

  localparam int AW  = etsa_pkg::AVG_W;
  localparam int PW  = etsa_pkg::PRICE_W;
  localparam int CW  = etsa_pkg::COUNT_WIDTH;
  localparam int SW  = etsa_pkg::SHARE_W;
  localparam int RW  = etsa_pkg::REM_W;
  localparam int NW  = etsa_pkg::NUM_W;
  localparam int XW  = etsa_pkg::NEXT_W;
  localparam int UW  = etsa_pkg::SUM_W;
  localparam logic [UW-1:0] ROUND_HALF = UW'(1) << (etsa_pkg::ALPHA_FRAC_BITS - 1);

  etsa_pkg::back_state_t                 state_r, state_nxt;
  logic [etsa_pkg::ALPHA_W-1:0]          alpha_r, alpha_nxt;
  logic [AW-1:0]                         avg_r, avg_nxt;
  logic [PW-1:0]                         prev_price_r, prev_price_nxt;
  logic                                  seeded_r, seeded_nxt;
  logic [CW-1:0]                         agree_r, agree_nxt;
  logic [CW-1:0]                         pair_r, pair_nxt;
  logic                                  out_valid_r, out_valid_nxt;

  logic [PW-1:0]                         cur_price_r, cur_price_nxt;
  logic                                  last_r, last_nxt;
  logic                                  neg_r, neg_nxt;
  logic [etsa_pkg::DIFF_W-1:0]           mag_r, mag_nxt;
  logic [etsa_pkg::PLO_W-1:0]            plo_r, plo_nxt;
  logic [etsa_pkg::PHI_W-1:0]            phi_r, phi_nxt;
  logic [etsa_pkg::STEP_W-1:0]           step_r, step_nxt;
  logic [RW-1:0]                         rem_r, rem_nxt;
  logic [SW-1:0]                         quo_r, quo_nxt;
  logic [SW-1:0]                         nbits_r, nbits_nxt;
  logic [etsa_pkg::DCNT_W-1:0]           dcnt_r, dcnt_nxt;
  logic [etsa_pkg::OUT_DATA_W-1:0]       out_data_r, out_data_nxt;
  logic                                  out_user_r, out_user_nxt;

  logic [AW-1:0]                         wide;
  logic [etsa_pkg::DIFF_W-1:0]           diff;
  logic [UW-1:0]                         sum;
  logic [XW-1:0]                         avg_ext, next_val;
  logic [AW-1:0]                         avg_new;
  logic                                  overflow;
  logic                                  ema_up, ema_dn, price_up, price_dn;
  logic [NW-1:0]                         num;
  logic [RW-1:0]                         den, trial;
  logic                                  ge;
  logic                                  has_pair;

  assign wide     = {head.price, {etsa_pkg::WIDE_SHIFT{1'b0}}};
  assign diff     = {wide[AW-1], wide} - {avg_r[AW-1], avg_r};
  assign sum      = (UW'(phi_r) << etsa_pkg::LO_W) + UW'(plo_r) + ROUND_HALF;
  assign avg_ext  = {{(XW - AW){avg_r[AW-1]}}, avg_r};
  assign next_val = neg_r ? avg_ext - XW'(step_r) : avg_ext + XW'(step_r);
  assign overflow = !((&next_val[XW-1:AW-1]) || !(|next_val[XW-1:AW-1]));
  assign avg_new  = overflow ? (next_val[XW-1] ? {1'b1, {(AW - 1){1'b0}}}
                                               : {1'b0, {(AW - 1){1'b1}}})
                             : next_val[AW-1:0];
  assign ema_up   = $signed(avg_new) > $signed(avg_r);
  assign ema_dn   = $signed(avg_new) < $signed(avg_r);
  assign price_up = $signed(cur_price_r) > $signed(prev_price_r);
  assign price_dn = $signed(cur_price_r) < $signed(prev_price_r);
  assign num      = (NW'(agree_r) << SW) + NW'(pair_r);
  assign den      = RW'({pair_r, 1'b0});
  assign trial    = {rem_r[RW-2:0], nbits_r[SW-1]};
  assign ge       = trial >= den;
  assign has_pair = (pair_r != '0);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  always_comb begin
    state_nxt      = state_r;
    alpha_nxt      = cfg_we ? cfg_wdata : alpha_r;
    avg_nxt        = avg_r;
    prev_price_nxt = prev_price_r;
    seeded_nxt     = seeded_r;
    agree_nxt      = agree_r;
    pair_nxt       = pair_r;
    cur_price_nxt  = cur_price_r;
    last_nxt       = last_r;
    neg_nxt        = neg_r;
    mag_nxt        = mag_r;
    plo_nxt        = plo_r;
    phi_nxt        = phi_r;
    step_nxt       = step_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    nbits_nxt      = nbits_r;
    dcnt_nxt       = dcnt_r;
    out_data_nxt   = out_data_r;
    out_user_nxt   = out_user_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    pop            = 1'b0;

    case (state_r)
      etsa_pkg::ST_IDLE: begin
        if (!q_status.empty) begin
          pop = 1'b1;
          case (head.kind)
            etsa_pkg::KIND_END: begin
              state_nxt = etsa_pkg::ST_DIVSET;
            end
            etsa_pkg::KIND_SAMPLE, etsa_pkg::KIND_SAMPLE_END: begin
              last_nxt      = (head.kind == etsa_pkg::KIND_SAMPLE_END);
              cur_price_nxt = head.price;
              if (!seeded_r) begin
                avg_nxt        = wide;
                prev_price_nxt = head.price;
                seeded_nxt     = 1'b1;
                state_nxt      = (head.kind == etsa_pkg::KIND_SAMPLE_END)
                                 ? etsa_pkg::ST_DIVSET : etsa_pkg::ST_IDLE;
              end else begin
                neg_nxt   = diff[etsa_pkg::DIFF_W-1];
                mag_nxt   = diff[etsa_pkg::DIFF_W-1] ? -diff : diff;
                state_nxt = etsa_pkg::ST_MUL;
              end
            end
            default: begin
              state_nxt = etsa_pkg::ST_IDLE;
            end
          endcase
        end
      end
      etsa_pkg::ST_MUL: begin
        plo_nxt   = etsa_pkg::PLO_W'(mag_r[etsa_pkg::LO_W-1:0])
                    * etsa_pkg::PLO_W'(alpha_r);
        phi_nxt   = etsa_pkg::PHI_W'(mag_r[etsa_pkg::DIFF_W-1:etsa_pkg::LO_W])
                    * etsa_pkg::PHI_W'(alpha_r);
        state_nxt = etsa_pkg::ST_STEP;
      end
      etsa_pkg::ST_STEP: begin
        step_nxt  = sum[UW-1:etsa_pkg::ALPHA_FRAC_BITS];
        state_nxt = etsa_pkg::ST_UPD;
      end
      etsa_pkg::ST_UPD: begin
        avg_nxt        = avg_new;
        prev_price_nxt = cur_price_r;
        if ((ema_up || ema_dn) && (price_up || price_dn)) begin
          if (((ema_up && price_up) || (ema_dn && price_dn)) && (agree_r != '1)) begin
            agree_nxt = agree_r + CW'(1);
          end
          if (pair_r != '1) begin
            pair_nxt = pair_r + CW'(1);
          end
        end
        state_nxt = last_r ? etsa_pkg::ST_DIVSET : etsa_pkg::ST_IDLE;
      end
      etsa_pkg::ST_DIVSET: begin
        quo_nxt   = '0;
        rem_nxt   = RW'(num[NW-1:SW]);
        nbits_nxt = num[SW-1:0];
        dcnt_nxt  = '0;
        state_nxt = has_pair ? etsa_pkg::ST_DIV : etsa_pkg::ST_DONE;
      end
      etsa_pkg::ST_DIV: begin
        rem_nxt   = ge ? trial - den : trial;
        quo_nxt   = {quo_r[SW-2:0], ge};
        nbits_nxt = {nbits_r[SW-2:0], 1'b0};
        dcnt_nxt  = dcnt_r + etsa_pkg::DCNT_W'(1);
        if (dcnt_r == etsa_pkg::DCNT_W'(SW - 1)) begin
          state_nxt = etsa_pkg::ST_DONE;
        end
      end
      etsa_pkg::ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_user_nxt   = has_pair;
          out_data_nxt   = etsa_pkg::OUT_DATA_W'({etsa_pkg::sat_total(pair_r),
                                                  etsa_pkg::sat_total(agree_r),
                                                  quo_r});
          avg_nxt        = '0;
          prev_price_nxt = '0;
          seeded_nxt     = 1'b0;
          agree_nxt      = '0;
          pair_nxt       = '0;
          state_nxt      = etsa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = etsa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= etsa_pkg::ST_IDLE;
      alpha_r      <= etsa_pkg::ALPHA_RESET;
      avg_r        <= '0;
      prev_price_r <= '0;
      seeded_r     <= 1'b0;
      agree_r      <= '0;
      pair_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      alpha_r      <= alpha_nxt;
      avg_r        <= avg_nxt;
      prev_price_r <= prev_price_nxt;
      seeded_r     <= seeded_nxt;
      agree_r      <= agree_nxt;
      pair_r       <= pair_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_price_r <= cur_price_nxt;
    last_r      <= last_nxt;
    neg_r       <= neg_nxt;
    mag_r       <= mag_nxt;
    plo_r       <= plo_nxt;
    phi_r       <= phi_nxt;
    step_r      <= step_nxt;
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    nbits_r     <= nbits_nxt;
    dcnt_r      <= dcnt_nxt;
    out_data_r  <= out_data_nxt;
    out_user_r  <= out_user_nxt;
  end

endmodule
`default_nettype wire

/* hdl/ema_trend_sign_agreement.sv */
// EMA trend sign agreement over a stream of price words.
// The input channel takes one price word per sample in signed Q16.16 on in_tdata,
// a missing flag on in_tuser and the end of a series on in_tlast. Missing samples
// that do not end a series are dropped at the front and cost no back-end time.
// Accepted words wait in a four-entry queue in front of the sequencer that runs
// the average, so the input keeps flowing while earlier words are still at work.
// The first present sample of a series only seeds the average; every later present
// sample runs the split multiply, the rounding add and the update in turn.
// A missing end word is popped from the queue and leads straight to the close of the
// series. Closing a series runs a setup step, the restoring divider for the 17-bit
// agreement share (skipped when no pair was counted) and the load of the output register.
// The result word leaves on out_tdata with share_valid on out_tuser. A result that
// the receiver stalls is held in the output register while the next series is
// processed; only the next result waits for the register to free up.
// The smoothing factor is written through cfg_we and cfg_wdata; the user must write
// it only while the block idles, as the block itself does not enforce this.
// Reset empties the queue, clears the series state and loads the factor 6242.
`default_nettype none
module ema_trend_sign_agreement (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [etsa_pkg::ALPHA_W-1:0]       cfg_wdata,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [etsa_pkg::PRICE_W-1:0]       in_tdata,   // [31:0] price
  input  wire logic                               in_tuser,   // [0] missing
  input  wire logic                               in_tlast,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // [16:0] share, [32:17] agree_total, [48:33] pair_total, [55:49] zero
  output logic [etsa_pkg::OUT_DATA_W-1:0]         out_tdata,
  output logic                                    out_tuser   // [0] share_valid
);

  etsa_pkg::q_status_t q_status;
  etsa_pkg::q_entry_t  push_entry;
  etsa_pkg::q_entry_t  head;
  logic                push;
  logic                pop;

  etsa_front u_front (
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .q_status   (q_status),
    .push       (push),
    .push_entry (push_entry)
  );

  etsa_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  etsa_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .head       (head),
    .q_status   (q_status),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire

/* bench/tb_top.sv */
`timescale 1ns / 100ps
module tb_top;

  typedef struct packed {
    logic [etsa_pkg::SHARE_W-1:0] share;
    logic                         valid;
    logic [etsa_pkg::TOTAL_W-1:0] agree;
    logic [etsa_pkg::TOTAL_W-1:0] pair;
  } share_word_t;

  typedef struct packed {
    logic [etsa_pkg::PRICE_W-1:0] price;
    logic                         miss;
    logic                         last;
    logic                         typed;
    share_word_t                  want;
  } dir_row_t;

  typedef enum int {
    SHAPE_WALK,
    SHAPE_NOISE,
    SHAPE_EXTREME,
    SHAPE_GAPS
  } series_shape_t;

  localparam share_word_t NO_PAIRS = '{share: '0, valid: 1'b0, agree: '0, pair: '0};
  localparam int     DIR_ROWS       = 20;
  localparam int     WATCHDOG_LIMIT = 2000;
  localparam int     SETTLE_CYCLES  = 64;
  localparam int     RANDOM_WORDS   = 1780;
  localparam longint AVG_TOP        = (64'sd1 <<< (etsa_pkg::AVG_W - 1)) - 1;
  localparam longint AVG_BOTTOM     = -AVG_TOP - 1;
  localparam longint COUNT_TOP      = (64'sd1 <<< etsa_pkg::COUNT_WIDTH) - 1;
  localparam longint TOTAL_TOP      = (64'sd1 <<< etsa_pkg::TOTAL_W) - 1;

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            cfg_we     = 1'b0;
  logic [etsa_pkg::ALPHA_W-1:0]    cfg_wdata  = '0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [etsa_pkg::PRICE_W-1:0]    in_tdata   = '0;
  logic                            in_tuser   = 1'b0;
  logic                            in_tlast   = 1'b0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [etsa_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                            out_tuser;

  ema_trend_sign_agreement u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #2 clk = ~clk;

  logic [etsa_pkg::ALPHA_W-1:0] alpha_now;
  longint                       ema_avg;
  longint                       prior_px;
  longint                       last_avg;
  bit                           seeded;
  longint                       agree_cnt;
  longint                       pair_cnt;

  share_word_t pending_shares[$];
  int          mismatch_count = 0;
  int          sent_words     = 0;
  int          burst_left     = 0;
  int          idle_cycles    = 0;
  int          stall_mode     = 0;
  int          stall_left     = 0;
  int          stall_phase    = 0;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{32'h0000_0000, 1'b1, 1'b1, 1'b1, NO_PAIRS},
    '{32'h7FFF_FFFF, 1'b0, 1'b1, 1'b1, NO_PAIRS},
    '{32'h8000_0000, 1'b0, 1'b0, 1'b0, NO_PAIRS},
    '{32'h8000_0000, 1'b1, 1'b0, 1'b0, NO_PAIRS},
    '{32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, NO_PAIRS},
    '{32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, NO_PAIRS},
    '{32'h8000_0000, 1'b0, 1'b1, 1'b0, NO_PAIRS},
    '{32'h0000_0064, 1'b0, 1'b0, 1'b0, NO_PAIRS},
    '{32'h0000_0064, 1'b0, 1'b1, 1'b1, NO_PAIRS},
    '{32'h0000_0000, 1'b0, 1'b0, 1'b0, NO_PAIRS},
    '{32'h0001_0000, 1'b0, 1'b0, 1'b0, NO_PAIRS},
    '{32'h0000_0000, 1'b0, 1'b0, 1'b0, NO_PAIRS},
    '{32'h0002_0000, 1'b1, 1'b1, 1'b0, NO_PAIRS},
    '{32'h0000_0005, 1'b0, 1'b0, 1'b0, NO_PAIRS},
    '{32'h0000_0007, 1'b0, 1'b0, 1'b0, NO_PAIRS},
    '{32'h0000_0003, 1'b0, 1'b1, 1'b0, NO_PAIRS},
    '{32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, NO_PAIRS},
    '{32'hFFFF_0000, 1'b0, 1'b0, 1'b0, NO_PAIRS},
    '{32'h0001_0000, 1'b1, 1'b0, 1'b0, NO_PAIRS},
    '{32'h0000_0001, 1'b0, 1'b1, 1'b0, NO_PAIRS}
  };

  function automatic void clear_series();
    ema_avg   = 0;
    prior_px  = 0;
    last_avg  = 0;
    seeded    = 1'b0;
    agree_cnt = 0;
    pair_cnt  = 0;
  endfunction

  function automatic int sign_of(input longint v);
    return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
  endfunction

  function automatic longint ema_next(input longint avg, input longint wide);
    longint      diff;
    logic [63:0] mag;
    logic [81:0] prod;
    logic [81:0] stp;
    longint      nxt;
    diff = wide - avg;
    mag  = (diff < 0) ? 64'(-diff) : 64'(diff);
    prod = 82'(mag) * 82'(alpha_now);
    stp  = (prod + (82'd1 << (etsa_pkg::ALPHA_FRAC_BITS - 1))) >> etsa_pkg::ALPHA_FRAC_BITS;
    nxt  = (diff < 0) ? avg - $signed(stp[63:0]) : avg + $signed(stp[63:0]);
    if (nxt > AVG_TOP) begin
      nxt = AVG_TOP;
    end
    if (nxt < AVG_BOTTOM) begin
      nxt = AVG_BOTTOM;
    end
    return nxt;
  endfunction

  function automatic bit advance_series(input logic [etsa_pkg::PRICE_W-1:0] price,
                                        input bit miss, input bit last,
                                        output share_word_t res);
    longint      p;
    longint      wide;
    int          sp;
    int          sa;
    logic [63:0] num;
    logic [63:0] den;
    res = NO_PAIRS;
    if (!miss) begin
      p    = longint'($signed(price));
      wide = p * 65536;
      if (!seeded) begin
        ema_avg  = wide;
        prior_px = p;
        last_avg = wide;
        seeded   = 1'b1;
      end else begin
        ema_avg = ema_next(ema_avg, wide);
        sp = sign_of(p - prior_px);
        sa = sign_of(ema_avg - last_avg);
        if (sp != 0 && sa != 0) begin
          if (sp == sa && agree_cnt < COUNT_TOP) begin
            agree_cnt++;
          end
          if (pair_cnt < COUNT_TOP) begin
            pair_cnt++;
          end
        end
        prior_px = p;
        last_avg = ema_avg;
      end
    end
    if (!last) begin
      return 1'b0;
    end
    if (pair_cnt > 0) begin
      num       = (64'(agree_cnt) << 17) + 64'(pair_cnt);
      den       = 64'(pair_cnt) << 1;
      res.share = etsa_pkg::SHARE_W'(num / den);
      res.valid = 1'b1;
    end
    res.agree = (agree_cnt > TOTAL_TOP) ? '1 : etsa_pkg::TOTAL_W'(agree_cnt);
    res.pair  = (pair_cnt > TOTAL_TOP) ? '1 : etsa_pkg::TOTAL_W'(pair_cnt);
    clear_series();
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t mismatch in %s: got %0d, want %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic send_word(input logic [etsa_pkg::PRICE_W-1:0] price, input bit miss,
                           input bit last, input bit typed, input share_word_t typed_want);
    int          gap;
    share_word_t res;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= price;
    in_tuser  <= miss;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    burst_left--;
    sent_words++;
    if (advance_series(price, miss, last, res)) begin
      pending_shares.push_back(typed ? typed_want : res);
    end
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_shares.size() != 0) @(posedge clk);
  endtask

  task automatic write_alpha(input logic [etsa_pkg::ALPHA_W-1:0] value);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    alpha_now = value;
  endtask

  task automatic run_series(input int len, input series_shape_t shape);
    logic [etsa_pkg::PRICE_W-1:0] price;
    logic [etsa_pkg::PRICE_W-1:0] base;
    bit                           miss;
    base = $urandom;
    for (int i = 0; i < len; i++) begin
      miss  = (shape == SHAPE_GAPS) || ($urandom_range(0, 6) == 0);
      price = $urandom;
      case (shape)
        SHAPE_WALK: begin
          case ($urandom_range(0, 3))
            0: price = base;
            1: price = base + $urandom_range(0, 255);
            2: price = base - $urandom_range(0, 255);
            default: price = base + ($urandom_range(0, 65535) << $urandom_range(0, 12));
          endcase
          base = price;
        end
        SHAPE_EXTREME: begin
          case ($urandom_range(0, 4))
            0: price = 32'h7FFF_FFFF;
            1: price = 32'h8000_0000;
            2: price = 32'h0000_0000;
            3: price = 32'hFFFF_FFFF;
            default: price = $urandom;
          endcase
        end
        default: begin
        end
      endcase
      send_word(price, miss, i == len - 1, 1'b0, NO_PAIRS);
    end
  endtask

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(50, 400);
    end else begin
      stall_left <= stall_left - 1;
    end
    stall_phase <= (stall_phase + 1) % 32;
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= ($urandom_range(0, 7) == 0);
      default: out_tready <= (stall_phase < 20);
    endcase
  end

  always @(posedge clk) begin : out_check
    share_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_shares.size() == 0) begin
        report_mismatch("result with nothing pending", out_tdata[etsa_pkg::SHARE_W-1:0], 0);
      end else begin
        want = pending_shares.pop_front();
        if (out_tdata[etsa_pkg::SHARE_W-1:0] != want.share) begin
          report_mismatch("share", out_tdata[etsa_pkg::SHARE_W-1:0], want.share);
        end
        if (out_tuser != want.valid) begin
          report_mismatch("share_valid", out_tuser, want.valid);
        end
        if (out_tdata[etsa_pkg::SHARE_W +: etsa_pkg::TOTAL_W] != want.agree) begin
          report_mismatch("agree_total", out_tdata[etsa_pkg::SHARE_W +: etsa_pkg::TOTAL_W],
                          want.agree);
        end
        if (out_tdata[etsa_pkg::SHARE_W + etsa_pkg::TOTAL_W +: etsa_pkg::TOTAL_W]
            != want.pair) begin
          report_mismatch("pair_total",
                          out_tdata[etsa_pkg::SHARE_W + etsa_pkg::TOTAL_W +: etsa_pkg::TOTAL_W],
                          want.pair);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [etsa_pkg::ALPHA_W-1:0] pick;
    series_shape_t                shape;
    int                           n_series;
    int                           len;
    int                           phase;
    int                           r;
    clear_series();
    alpha_now = etsa_pkg::ALPHA_RESET;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_word(dir_rows[i].price, dir_rows[i].miss, dir_rows[i].last,
                dir_rows[i].typed, dir_rows[i].want);
    end

    phase      = 0;
    sent_words = 0;
    while (sent_words < RANDOM_WORDS) begin
      case (phase)
        0: pick = 16'd1;
        1: pick = 16'hFFFF;
        2: pick = 16'h8000;
        default: begin
          case ($urandom_range(0, 4))
            0: pick = 16'd1;
            1: pick = 16'hFFFF;
            2: pick = etsa_pkg::ALPHA_RESET;
            default: pick = etsa_pkg::ALPHA_W'($urandom_range(1, 65535));
          endcase
        end
      endcase
      write_alpha(pick);
      n_series = $urandom_range(3, 12);
      for (int s = 0; s < n_series && sent_words < RANDOM_WORDS; s++) begin
        r = $urandom_range(0, 9);
        if (r < 6) begin
          shape = SHAPE_WALK;
        end else if (r < 8) begin
          shape = SHAPE_NOISE;
        end else if (r < 9) begin
          shape = SHAPE_EXTREME;
        end else begin
          shape = SHAPE_GAPS;
        end
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
        run_series(len, shape);
        if ($urandom_range(0, 9) == 0) begin
          drain_results();
        end
      end
      phase++;
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_shares.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/etsa_pkg.sv
hdl/etsa_front.sv
hdl/etsa_fifo.sv
hdl/etsa_back.sv
hdl/ema_trend_sign_agreement.sv
bench/tb_top.sv
